// File: rtl/pcc_pkg.sv
`default_nettype none
package pcc_pkg;

    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    // post-accumulation math is carried modulo 2^64
    localparam int MW          = 64;
    localparam int CORR_W      = 16;
    localparam int PCNT_W      = 11;
    localparam int OUT_TDATA_W = ((CORR_W + PCNT_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 2;

    localparam int MUL_STEPS   = MW;
    localparam int SQRT_STEPS  = MW;
    localparam int DIV_STEPS   = CORR_W - 1;
    localparam int STEP_CNT_W  = $clog2(MW);

    localparam logic [CORR_W-1:0] CORR_MAX = 16'h7FFF;
    localparam logic [CORR_W-1:0] CORR_MIN = 16'h8000;

    // product schedule of the shared multiplier
    localparam logic [2:0] SEL_NAB = 3'd0;  // n * sum(ab)
    localparam logic [2:0] SEL_AB  = 3'd1;  // sum(a) * sum(b)
    localparam logic [2:0] SEL_NAA = 3'd2;  // n * sum(a^2)
    localparam logic [2:0] SEL_AA  = 3'd3;  // sum(a)^2
    localparam logic [2:0] SEL_NBB = 3'd4;  // n * sum(b^2)
    localparam logic [2:0] SEL_BB  = 3'd5;  // sum(b)^2
    localparam logic [2:0] SEL_RAD = 3'd6;  // sxx * syy, full width

    typedef struct packed {
        logic       acc_en;
        logic       clear;
        logic       mul_start;
        logic       mul_capture;
        logic [2:0] mul_sel;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic few;
        logic mul_done;
        logic d_zero;
        logic mag_ge;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

// File: rtl/pcc_mul.sv
`default_nettype none
module pcc_mul (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [pcc_pkg::MW-1:0]  i_a,
    input  wire logic [pcc_pkg::MW-1:0]  i_b,
    output logic                         o_done,
    output logic [2*pcc_pkg::MW-1:0]     o_prod
);

    localparam int MW = pcc_pkg::MW;
    localparam int CW = pcc_pkg::STEP_CNT_W;

    logic [MW-1:0] r_hi;
    logic [MW-1:0] r_lo;
    logic [MW-1:0] r_mc;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [MW:0]   sum;

    // shift-add, one multiplier bit per cycle, low half shifts out of r_lo
    assign sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mc} : {(MW+1){1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= CW'(r_cnt + 1'b1);
                if (r_cnt == CW'(pcc_pkg::MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hi <= '0;
            r_lo <= i_b;
            r_mc <= i_a;
        end else if (r_busy) begin
            r_hi <= sum[MW:1];
            r_lo <= {sum[0], r_lo[MW-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

endmodule
`default_nettype wire

// File: rtl/pcc_dp.sv
`default_nettype none
module pcc_dp #(
    parameter int MAX_SAMPLES = pcc_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = pcc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire pcc_pkg::t_cmd                  i_cmd,
    output pcc_pkg::t_stat                      o_stat,
    input  wire logic signed [SAMPLE_BITS-1:0]  i_sample_a,
    input  wire logic signed [SAMPLE_BITS-1:0]  i_sample_b,
    input  wire logic                           i_m_tready,
    output logic                                o_m_tvalid,
    output logic [pcc_pkg::CORR_W-1:0]          o_correlation,
    output logic                                o_degenerate,
    output logic                                o_overflow,
    output logic [pcc_pkg::PCNT_W-1:0]          o_pair_count
);

    localparam int MW     = pcc_pkg::MW;
    localparam int CORR_W = pcc_pkg::CORR_W;
    localparam int QW     = pcc_pkg::DIV_STEPS;
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int SQ_W   = 2 * SAMPLE_BITS - 1 + CNT_W;
    localparam int XP_W   = 2 * SAMPLE_BITS + CNT_W;
    localparam int REM_W  = MW + 4;

    // accumulators
    logic [CNT_W-1:0]        r_n;
    logic signed [SUM_W-1:0] r_sa;
    logic signed [SUM_W-1:0] r_sb;
    logic [SQ_W-1:0]         r_saa;
    logic [SQ_W-1:0]         r_sbb;
    logic signed [XP_W-1:0]  r_sab;
    logic                    r_drop;

    logic signed [2*SAMPLE_BITS-1:0] paa;
    logic signed [2*SAMPLE_BITS-1:0] pbb;
    logic signed [2*SAMPLE_BITS-1:0] pab;

    assign paa = i_sample_a * i_sample_a;
    assign pbb = i_sample_b * i_sample_b;
    assign pab = i_sample_a * i_sample_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_n    <= '0;
            r_sa   <= '0;
            r_sb   <= '0;
            r_saa  <= '0;
            r_sbb  <= '0;
            r_sab  <= '0;
            r_drop <= 1'b0;
        end else if (i_cmd.acc_en) begin
            if (r_n < CNT_W'(MAX_SAMPLES)) begin
                r_n   <= CNT_W'(r_n + 1'b1);
                r_sa  <= r_sa + SUM_W'(i_sample_a);
                r_sb  <= r_sb + SUM_W'(i_sample_b);
                r_saa <= r_saa + SQ_W'(paa[2*SAMPLE_BITS-2:0]);
                r_sbb <= r_sbb + SQ_W'(pbb[2*SAMPLE_BITS-2:0]);
                r_sab <= r_sab + XP_W'(pab);
            end else begin
                r_drop <= 1'b1;
            end
        end
    end

    // shared multiplier and its operand schedule
    logic [MW-1:0]   op_a;
    logic [MW-1:0]   op_b;
    logic [MW-1:0]   n64;
    logic [MW-1:0]   sa64;
    logic [MW-1:0]   sb64;
    logic            mul_done;
    logic [2*MW-1:0] prod;

    assign n64  = MW'(r_n);
    assign sa64 = MW'(r_sa);
    assign sb64 = MW'(r_sb);

    logic [MW-1:0] r_num;
    logic [MW-1:0] r_sxx;
    logic [MW-1:0] r_syy;

    always_comb begin
        case (i_cmd.mul_sel)
            pcc_pkg::SEL_NAB: begin
                op_a = n64;
                op_b = MW'(r_sab);
            end
            pcc_pkg::SEL_AB: begin
                op_a = sa64;
                op_b = sb64;
            end
            pcc_pkg::SEL_NAA: begin
                op_a = n64;
                op_b = MW'(r_saa);
            end
            pcc_pkg::SEL_AA: begin
                op_a = sa64;
                op_b = sa64;
            end
            pcc_pkg::SEL_NBB: begin
                op_a = n64;
                op_b = MW'(r_sbb);
            end
            pcc_pkg::SEL_BB: begin
                op_a = sb64;
                op_b = sb64;
            end
            pcc_pkg::SEL_RAD: begin
                op_a = r_sxx;
                op_b = r_syy;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    pcc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    // root and quotient work registers
    logic [2*MW-1:0]  r_rad;
    logic [MW-1:0]    r_root;
    logic [REM_W-1:0] r_rem;
    logic [MW-1:0]    r_mag;
    logic [MW-1:0]    r_drem;
    logic [QW-1:0]    r_q;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             take;
    logic [MW:0]      drem_sh;
    logic             dtake;
    logic             neg;

    assign rem_sh  = {r_rem[REM_W-3:0], r_rad[2*MW-1:2*MW-2]};
    assign trial   = {2'b00, r_root, 2'b01};
    assign take    = rem_sh >= trial;
    assign drem_sh = {r_drem, 1'b0};
    assign dtake   = drem_sh >= {1'b0, r_root};
    assign neg     = r_num[MW-1];

    always_ff @(posedge i_clk) begin
        r_mag <= neg ? MW'(-r_num) : r_num;
        if (i_cmd.mul_capture) begin
            case (i_cmd.mul_sel)
                pcc_pkg::SEL_NAB: r_num <= prod[MW-1:0];
                pcc_pkg::SEL_AB:  r_num <= r_num - prod[MW-1:0];
                pcc_pkg::SEL_NAA: r_sxx <= prod[MW-1:0];
                pcc_pkg::SEL_AA:  r_sxx <= r_sxx - prod[MW-1:0];
                pcc_pkg::SEL_NBB: r_syy <= prod[MW-1:0];
                pcc_pkg::SEL_BB:  r_syy <= r_syy - prod[MW-1:0];
                pcc_pkg::SEL_RAD: begin
                    r_rad  <= prod;
                    r_root <= '0;
                    r_rem  <= '0;
                end
                default: ;
            endcase
        end
        // restoring square root, two radicand bits per step
        if (i_cmd.sqrt_step) begin
            r_rad <= {r_rad[2*MW-3:0], 2'b00};
            if (take) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[MW-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[MW-2:0], 1'b0};
            end
        end
        if (i_cmd.div_init) begin
            r_drem <= r_mag;
            r_q    <= '0;
        end else if (i_cmd.div_step) begin
            // remainder stays below the divisor, so the shifted value is < 2d
            if (dtake) begin
                r_drem <= MW'(drem_sh - {1'b0, r_root});
                r_q    <= {r_q[QW-2:0], 1'b1};
            end else begin
                r_drem <= drem_sh[MW-1:0];
                r_q    <= {r_q[QW-2:0], 1'b0};
            end
        end
    end

    // result selection and output register
    logic              few;
    logic              d_zero;
    logic              mag_ge;
    logic [CORR_W-1:0] res_corr;
    logic              res_degen;
    logic [MW-1:0]     cnt64;
    logic              r_ovalid;

    assign few    = r_n < CNT_W'(2);
    assign d_zero = r_root == '0;
    assign mag_ge = r_mag >= r_root;
    assign cnt64  = MW'(r_n);

    always_comb begin
        res_degen = 1'b0;
        if (few) begin
            res_corr  = (r_n == CNT_W'(1)) ? pcc_pkg::CORR_MAX : '0;
            res_degen = r_n == '0;
        end else if (d_zero) begin
            res_corr  = '0;
            res_degen = 1'b1;
        end else if (mag_ge) begin
            res_corr = neg ? pcc_pkg::CORR_MIN : pcc_pkg::CORR_MAX;
        end else begin
            res_corr = neg ? CORR_W'(-{1'b0, r_q}) : {1'b0, r_q};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_correlation <= res_corr;
            o_degenerate  <= res_degen;
            o_overflow    <= r_drop;
            o_pair_count  <= cnt64[pcc_pkg::PCNT_W-1:0];
        end
    end

    assign o_m_tvalid      = r_ovalid;
    assign o_stat.few      = few;
    assign o_stat.mul_done = mul_done;
    assign o_stat.d_zero   = d_zero;
    assign o_stat.mag_ge   = mag_ge;
    assign o_stat.out_free = !r_ovalid || i_m_tready;

endmodule
`default_nettype wire

// File: rtl/pcc_ctrl.sv
`default_nettype none
module pcc_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    input  wire logic            i_s_tlast,
    output logic                 o_s_tready,
    input  wire pcc_pkg::t_stat  i_stat,
    output pcc_pkg::t_cmd        o_cmd
);

    localparam int CW = pcc_pkg::STEP_CNT_W;

    localparam logic [2:0] ST_ACC   = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_MGO   = 3'd2;
    localparam logic [2:0] ST_MWAIT = 3'd3;
    localparam logic [2:0] ST_SQRT  = 3'd4;
    localparam logic [2:0] ST_DINIT = 3'd5;
    localparam logic [2:0] ST_DIV   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0]    r_state;
    logic [2:0]    n_state;
    logic [2:0]    r_sel;
    logic [2:0]    n_sel;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;

    always_comb begin
        n_state       = r_state;
        n_sel         = r_sel;
        n_cnt         = r_cnt;
        o_cmd         = '0;
        o_cmd.mul_sel = r_sel;
        case (r_state)
            ST_ACC: begin
                o_cmd.acc_en = i_s_tvalid;
                if (i_s_tvalid && i_s_tlast) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_sel   = pcc_pkg::SEL_NAB;
                n_state = i_stat.few ? ST_OUT : ST_MGO;
            end
            ST_MGO: begin
                o_cmd.mul_start = 1'b1;
                n_state         = ST_MWAIT;
            end
            ST_MWAIT: begin
                if (i_stat.mul_done) begin
                    o_cmd.mul_capture = 1'b1;
                    if (r_sel == pcc_pkg::SEL_RAD) begin
                        n_cnt   = '0;
                        n_state = ST_SQRT;
                    end else begin
                        n_sel   = 3'(r_sel + 3'd1);
                        n_state = ST_MGO;
                    end
                end
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt           = CW'(r_cnt + 1'b1);
                if (r_cnt == CW'(pcc_pkg::SQRT_STEPS - 1)) begin
                    n_state = ST_DINIT;
                end
            end
            ST_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = (i_stat.d_zero || i_stat.mag_ge) ? ST_OUT : ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = CW'(r_cnt + 1'b1);
                if (r_cnt == CW'(pcc_pkg::DIV_STEPS - 1)) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.clear    = 1'b1;
                    n_state        = ST_ACC;
                end
            end
            default: n_state = ST_ACC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACC;
            r_sel   <= pcc_pkg::SEL_NAB;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_cnt   <= n_cnt;
        end
    end

    assign o_s_tready = r_state == ST_ACC;

endmodule
`default_nettype wire

// File: rtl/pearson_correlation_core.sv
`default_nettype none
// Pearson correlation of paired signed samples. Each request on the slave side
// carries one pair (sample_a low, sample_b above it in tdata) and is absorbed
// into the running sums, so a run streams at one pair per clock. The request
// with tlast closes the run: tready then drops while the coefficient is formed
// with exact integer math by the shared shift-add multiplier (seven products),
// the 64-step square root and the 15-step quotient. A saturated or degenerate
// result skips the quotient, and a run of fewer than two pairs skips all of
// them. Loading the result may also wait for a free output register. The
// result is a Q1.15 coefficient with the pair count in tdata, and degenerate
// (bit 0) and overflow (bit 1) in tuser. Pairs past MAX_SAMPLES are dropped and
// flagged; the sums clear after each result. A finished result waits in an
// output register, and accumulation of the next run starts while it is still held.
module pearson_correlation_core #(
    parameter int MAX_SAMPLES = pcc_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = pcc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_s_tvalid,
    output logic                                        o_s_tready,
    // sample_a, sample_b, zero fill
    input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     i_s_tdata,
    input  wire logic                                   i_s_tlast,
    output logic                                        o_m_tvalid,
    input  wire logic                                   i_m_tready,
    // correlation, pair_count, zero fill
    output logic [pcc_pkg::OUT_TDATA_W-1:0]             o_m_tdata,
    // degenerate, overflow
    output logic [pcc_pkg::OUT_TUSER_W-1:0]             o_m_tuser
);

    pcc_pkg::t_cmd  cmd;
    pcc_pkg::t_stat stat;

    logic signed [SAMPLE_BITS-1:0]  sample_a;
    logic signed [SAMPLE_BITS-1:0]  sample_b;
    logic [pcc_pkg::CORR_W-1:0]     correlation;
    logic                           degenerate;
    logic                           overflow;
    logic [pcc_pkg::PCNT_W-1:0]     pair_count;

    assign sample_a = i_s_tdata[SAMPLE_BITS-1:0];
    assign sample_b = i_s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

    pcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pcc_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_sample_a    (sample_a),
        .i_sample_b    (sample_b),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_correlation (correlation),
        .o_degenerate  (degenerate),
        .o_overflow    (overflow),
        .o_pair_count  (pair_count)
    );

    assign o_m_tdata = pcc_pkg::OUT_TDATA_W'({pair_count, correlation});
    assign o_m_tuser = {overflow, degenerate};

    // the closing request of a run stalls the input while the result is formed
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=> !o_s_tready)
        else $error("input still ready after closing request");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata[pcc_pkg::CORR_W-1:0] == '0))
        else $error("degenerate result with nonzero coefficient");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |->
            (o_m_tdata[pcc_pkg::CORR_W+pcc_pkg::PCNT_W-1:pcc_pkg::CORR_W] != '0))
        else $error("result with zero pair count");

endmodule
`default_nettype wire
